/* src/pac_pkg.sv */
// Shared constants, opcodes and controller/datapath interface types for the polygon block.
package pac_pkg;

   localparam int MAX_VERTICES = 256;
   localparam int COORD_WIDTH  = 28;

   localparam int IDX_W   = $clog2(MAX_VERTICES);
   localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
   localparam int RAM_W   = 2 * COORD_WIDTH;
   localparam int DIFF_W  = COORD_WIDTH + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int CROSS_W = 2 * COORD_WIDTH;
   localparam int ACC_W   = 2 * COORD_WIDTH + IDX_W + 2;
   localparam int AREA_W  = 58;
   localparam int OP_W    = 2;

   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

   localparam logic [AREA_W-1:0] AREA_SAT = AREA_W'(1) << 57;

   typedef struct packed {
      logic             accept_imm;
      logic             clear;
      logic             append;
      logic             q_start;
      logic             rd_en;
      logic             rd_first;
      logic [IDX_W-1:0] rd_addr;
      logic             finalize;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
   } stat_type;

endpackage

/* src/pac_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module pac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/pac_ctrl.sv */
// Controller: accepts words, sequences the vertex walk for queries and strobes results.
module pac_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [pac_pkg::OP_W-1:0]     req_opcode,
   input  pac_pkg::stat_type            stat,
   output pac_pkg::cmd_type             cmd,
   output logic                         busy,
   output logic                         rsp_valid
);
   import pac_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_WALK    = 3'd1;
   localparam logic [2:0] ST_DRAIN_A = 3'd2;
   localparam logic [2:0] ST_DRAIN_B = 3'd3;
   localparam logic [2:0] ST_FINAL   = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_opcode == OP_QUERY) begin
                  cmd.q_start = 1'b1;
                  k_in        = '0;
                  state_in    = (stat.count == '0) ? ST_FINAL : ST_WALK;
               end else begin
                  cmd.accept_imm = 1'b1;
                  cmd.clear      = (req_opcode == OP_CLEAR);
                  cmd.append     = (req_opcode == OP_APPEND);
               end
            end
         end
         ST_WALK: begin
            // first read fetches the last vertex, then vertices 0 .. n-1
            cmd.rd_en    = 1'b1;
            cmd.rd_first = (k_ff == '0);
            cmd.rd_addr  = (k_ff == '0) ? IDX_W'(stat.count - 1'b1) : IDX_W'(k_ff - 1'b1);
            k_in         = k_ff + 1'b1;
            if (k_ff == stat.count) begin
               state_in = ST_DRAIN_A;
            end
         end
         ST_DRAIN_A: state_in = ST_DRAIN_B;
         ST_DRAIN_B: state_in = ST_FINAL;
         ST_FINAL: begin
            cmd.finalize = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.accept_imm | cmd.finalize;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* src/pac_dp.sv */
// Datapath: vertex store, edge products, area accumulator, crossing parity and result registers.
module pac_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  pac_pkg::cmd_type                    cmd,
   input  logic signed [pac_pkg::COORD_WIDTH-1:0] req_lon,
   input  logic signed [pac_pkg::COORD_WIDTH-1:0] req_lat,
   output pac_pkg::stat_type                   stat,
   output logic                                rsp_inside_res,
   output logic [pac_pkg::AREA_W-1:0]          rsp_twice_area,
   output logic [pac_pkg::CNT_W-1:0]           rsp_vertex_count,
   output logic                                rsp_status
);
   import pac_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             full;
   logic             wr_en;
   logic [RAM_W-1:0] rd_data;

   logic                           rd_v_ff, rd_first_ff;
   logic signed [COORD_WIDTH-1:0]  px_ff, py_ff;
   logic signed [COORD_WIDTH-1:0]  prev_lon_ff, prev_lat_ff;
   logic signed [COORD_WIDTH-1:0]  cur_lon, cur_lat;

   logic signed [DIFF_W-1:0]  dy, dxp, dxe, dyp;
   logic signed [PROD_W-1:0]  l_prod, r_prod;
   logic signed [CROSS_W-1:0] a_prod, b_prod;
   logic                      cond;

   logic                      s1_v_ff, s1_cond_ff, s1_dypos_ff;
   logic signed [PROD_W-1:0]  s1_l_ff, s1_r_ff;
   logic signed [CROSS_W-1:0] s1_a_ff, s1_b_ff;

   logic signed [ACC_W-1:0]   acc_ff;
   logic                      inside_ff;
   logic                      hit;
   logic [ACC_W-1:0]          acc_abs;
   logic [AREA_W-1:0]         area_sat;

   logic                      rsp_inside_ff, rsp_status_ff;
   logic [AREA_W-1:0]         rsp_area_ff;
   logic [CNT_W-1:0]          rsp_count_ff;

   assign full  = (count_ff == CNT_W'(MAX_VERTICES));
   assign wr_en = cmd.append && !full;

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + 1'b1;
      end
   end

   pac_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_VERTICES)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({req_lon, req_lat}),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_data)
   );

   assign cur_lon = rd_data[RAM_W-1:COORD_WIDTH];
   assign cur_lat = rd_data[COORD_WIDTH-1:0];

   // edge from previous vertex j to current vertex i
   assign cond   = (cur_lat > py_ff) != (prev_lat_ff > py_ff);
   assign dy     = DIFF_W'(prev_lat_ff) - DIFF_W'(cur_lat);
   assign dxp    = DIFF_W'(px_ff) - DIFF_W'(cur_lon);
   assign dxe    = DIFF_W'(prev_lon_ff) - DIFF_W'(cur_lon);
   assign dyp    = DIFF_W'(py_ff) - DIFF_W'(cur_lat);
   assign l_prod = dxp * dy;
   assign r_prod = dxe * dyp;
   assign a_prod = prev_lon_ff * cur_lat;
   assign b_prod = cur_lon * prev_lat_ff;

   assign hit = s1_cond_ff && (s1_dypos_ff ? (s1_l_ff < s1_r_ff) : (s1_l_ff > s1_r_ff));

   assign acc_abs  = acc_ff[ACC_W-1] ? (~acc_ff + 1'b1) : acc_ff;
   assign area_sat = (acc_abs > ACC_W'(AREA_SAT)) ? AREA_SAT : acc_abs[AREA_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         rd_v_ff     <= 1'b0;
         rd_first_ff <= 1'b0;
         s1_v_ff     <= 1'b0;
      end else begin
         count_ff    <= count_in;
         rd_v_ff     <= cmd.rd_en;
         rd_first_ff <= cmd.rd_first;
         s1_v_ff     <= rd_v_ff && !rd_first_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.q_start) begin
         px_ff     <= req_lon;
         py_ff     <= req_lat;
         acc_ff    <= '0;
         inside_ff <= 1'b0;
      end else if (s1_v_ff) begin
         acc_ff    <= acc_ff + ACC_W'(s1_a_ff) - ACC_W'(s1_b_ff);
         inside_ff <= inside_ff ^ hit;
      end

      if (rd_v_ff) begin
         prev_lon_ff <= cur_lon;
         prev_lat_ff <= cur_lat;
      end

      s1_cond_ff  <= cond;
      s1_dypos_ff <= (dy > 0);
      s1_l_ff     <= l_prod;
      s1_r_ff     <= r_prod;
      s1_a_ff     <= a_prod;
      s1_b_ff     <= b_prod;

      if (cmd.accept_imm) begin
         rsp_inside_ff <= 1'b0;
         rsp_area_ff   <= '0;
         rsp_count_ff  <= count_in;
         rsp_status_ff <= cmd.append && full;
      end else if (cmd.finalize) begin
         rsp_inside_ff <= inside_ff;
         rsp_area_ff   <= area_sat;
         rsp_count_ff  <= count_ff;
         rsp_status_ff <= 1'b0;
      end
   end

   assign stat.count       = count_ff;
   assign rsp_inside_res   = rsp_inside_ff;
   assign rsp_twice_area   = rsp_area_ff;
   assign rsp_vertex_count = rsp_count_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

/* src/polygon_area_and_containment.sv */
// Top level of the polygon store with shoelace area and even-odd containment.
//
//  channel  ports                                   handshake
//  request  req_opcode, req_lon, req_lat            start && !busy
//  response rsp_inside_res, rsp_twice_area,         rsp_valid, one cycle
//           rsp_vertex_count, rsp_status
//
// Clear, append and unused opcodes leave busy low; the result is strobed on the next cycle.
// A query on n stored vertices holds busy for n+1 vertex reads through the single RAM
// read port, two product/accumulate stages and one finalize; only the finalize when empty.
// Result of a query strobes on the cycle busy falls.
// Reset is synchronous; it clears the vertex count and control, not the vertex RAM.
// The receiver cannot stall; a new word may be taken while a result is strobed.
module polygon_area_and_containment (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [pac_pkg::OP_W-1:0]               req_opcode,
   input  logic signed [pac_pkg::COORD_WIDTH-1:0] req_lon,
   input  logic signed [pac_pkg::COORD_WIDTH-1:0] req_lat,
   output logic                                   rsp_valid,
   output logic                                   rsp_inside_res,
   output logic [pac_pkg::AREA_W-1:0]             rsp_twice_area,
   output logic [pac_pkg::CNT_W-1:0]              rsp_vertex_count,
   output logic                                   rsp_status
);
   import pac_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   pac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_valid  (rsp_valid)
   );

   pac_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_lon          (req_lon),
      .req_lat          (req_lat),
      .stat             (stat),
      .rsp_inside_res   (rsp_inside_res),
      .rsp_twice_area   (rsp_twice_area),
      .rsp_vertex_count (rsp_vertex_count),
      .rsp_status       (rsp_status)
   );

`ifndef SYNTHESIS
   a_imm_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode != OP_QUERY) |=> rsp_valid)
      else $error("immediate word produced no result");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_vertex_count <= CNT_W'(MAX_VERTICES)))
      else $error("vertex count out of range");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_vertex_count == CNT_W'(MAX_VERTICES)))
      else $error("append dropped while store not full");

   a_area_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_twice_area <= AREA_SAT))
      else $error("area above saturation value");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == OP_QUERY) |=> busy)
      else $error("query did not hold busy");
`endif

endmodule
